[rtl/core/positional_char_list_defines.svh]
// Assertion macros for the positional character list.
// Included by the RTL files that check their own control logic.
`ifndef POSITIONAL_CHAR_LIST_DEFINES_SVH
`define POSITIONAL_CHAR_LIST_DEFINES_SVH

`ifndef SYNTHESIS
`define PLC_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("plc assertion failed");
`define PLC_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("plc assertion failed");
`else
`define PLC_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define PLC_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

[rtl/core/plc_pkg.sv]
// Shared types and constants of the positional character list.
// No dependencies; used by plc_cell and positional_char_list.
`default_nettype none

package plc_pkg;

    localparam int POS_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int CAPACITY_D = 32;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DEL   = 2'd1,
        OP_GET   = 2'd2,
        OP_PRINT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_CHAR    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_INS  = 2'd1,
        CMD_DEL  = 2'd2,
        CMD_ROT  = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd        cmd;
        logic [POS_W-1:0] sel;
    } t_cell_ctl;

    typedef struct packed {
        t_op               op;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] item;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_out;

endpackage

`default_nettype wire

[rtl/core/positional_char_list.sv]
// Positional character list: an ordered list of up to CAPACITY characters in a
// row of cells, addressed by 1-based position. Add and delete shift all cells in
// parallel, so one add, delete or get is taken per cycle while the output
// register drains. Print streams one character per cycle while the output is
// accepted, by rotating the chain toward cell 0; the list is back in order
// when it ends. Depends on plc_pkg, plc_cell and the defines header.
`default_nettype none
`include "positional_char_list_defines.svh"

module positional_char_list #(
    parameter int CAPACITY = plc_pkg::CAPACITY_D
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire plc_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output plc_pkg::t_out      o_out_data
);
    import plc_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    typedef enum logic {
        S_IDLE,
        S_PRINT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_left;
    logic              r_out_valid;
    t_out              r_out;

    logic              w_slot;
    logic              w_accept;
    logic              w_load;
    logic [POS_W-1:0]  w_k;
    logic [CMP_W-1:0]  w_pos_c;
    logic [CMP_W-1:0]  w_cnt_c;
    logic              w_add_bad;
    logic              w_rd_bad;
    logic              w_full;
    t_cell_ctl         w_ctl;
    logic [CHAR_W-1:0] w_cells [CAPACITY];
    logic [CHAR_W-1:0] w_get;

    assign w_slot     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_slot;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_k       = i_in_data.position - 1'b1;
    assign w_pos_c   = CMP_W'(i_in_data.position);
    assign w_cnt_c   = CMP_W'(r_count);
    assign w_add_bad = (i_in_data.position == '0) || (w_pos_c > w_cnt_c + 1'b1);
    assign w_rd_bad  = (i_in_data.position == '0) || (w_pos_c > w_cnt_c);
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_get     = w_cells[w_k[IDX_W-1:0]];

    assign w_load = (w_ctl.cmd == CMD_ROT) ||
                    (w_accept && (w_ctl.cmd == CMD_HOLD) &&
                     !(i_in_data.op == OP_PRINT && r_count != '0));

    always_comb begin
        w_ctl.cmd = CMD_HOLD;
        w_ctl.sel = w_k;
        if (r_state == S_PRINT) begin
            w_ctl.sel = POS_W'(r_count - 1'b1);
            if (w_slot) begin
                w_ctl.cmd = CMD_ROT;
            end
        end else if (w_accept) begin
            if (i_in_data.op == OP_ADD && !w_add_bad && !w_full) begin
                w_ctl.cmd = CMD_INS;
            end else if (i_in_data.op == OP_DEL && !w_rd_bad) begin
                w_ctl.cmd = CMD_DEL;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [CHAR_W-1:0] w_left;
        logic [CHAR_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_cells[g+1];
        end
        plc_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cells[0]),
            .i_item  (i_in_data.item),
            .o_data  (w_cells[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_in_data.op)
                            OP_ADD: begin
                                if (w_add_bad) begin
                                    r_out_valid <= 1'b1;
                                    r_out       <= '{ST_INVALID, '0, 1'b1};
                                end else if (w_full) begin
                                    r_out_valid <= 1'b1;
                                    r_out       <= '{ST_FULL, '0, 1'b1};
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            OP_DEL: begin
                                if (w_rd_bad) begin
                                    r_out_valid <= 1'b1;
                                    r_out       <= '{ST_INVALID, '0, 1'b1};
                                end else begin
                                    r_count <= r_count - 1'b1;
                                end
                            end
                            OP_GET: begin
                                r_out_valid <= 1'b1;
                                if (w_rd_bad) begin
                                    r_out <= '{ST_INVALID, '0, 1'b1};
                                end else begin
                                    r_out <= '{ST_CHAR, w_get, 1'b1};
                                end
                            end
                            OP_PRINT: begin
                                if (r_count == '0) begin
                                    r_out_valid <= 1'b1;
                                    r_out       <= '{ST_EMPTY, '0, 1'b1};
                                end else begin
                                    r_state <= S_PRINT;
                                    r_left  <= r_count;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PRINT: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{ST_CHAR, w_cells[0], (r_left == CNT_W'(1))};
                        r_left      <= r_left - 1'b1;
                        if (r_left == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PLC_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `PLC_ASSERT_IMP(a_print_left, i_clk, i_rst_n, r_state == S_PRINT, r_left != '0)
    `PLC_ASSERT_IMP(a_stall_block, i_clk, i_rst_n, r_out_valid && !i_out_ready, !o_in_ready)
    `PLC_ASSERT_NXT(a_print_end, i_clk, i_rst_n,
        r_state == S_PRINT && w_slot && r_left == CNT_W'(1),
        r_state == S_IDLE && r_out_valid && r_out.last)

endmodule

`default_nettype wire

[rtl/core/plc_cell.sv]
// One storage cell of the list chain: holds one character and takes its
// neighbor's, the item or the head character on the broadcast command. Uses plc_pkg.
`default_nettype none

module plc_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                      i_clk,
    input  wire plc_pkg::t_cell_ctl        i_ctl,
    input  wire logic [plc_pkg::CHAR_W-1:0] i_left,
    input  wire logic [plc_pkg::CHAR_W-1:0] i_right,
    input  wire logic [plc_pkg::CHAR_W-1:0] i_head,
    input  wire logic [plc_pkg::CHAR_W-1:0] i_item,
    output logic      [plc_pkg::CHAR_W-1:0] o_data
);
    import plc_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [CHAR_W-1:0] r_data;
    logic [CHAR_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.cmd)
            CMD_HOLD: n_data = r_data;
            CMD_INS: begin
                if (IDX > i_ctl.sel) begin
                    n_data = i_left;
                end else if (IDX == i_ctl.sel) begin
                    n_data = i_item;
                end
            end
            CMD_DEL: begin
                if (IDX >= i_ctl.sel) begin
                    n_data = i_right;
                end
            end
            CMD_ROT: begin
                if (IDX == i_ctl.sel) begin
                    n_data = i_head;
                end else if (IDX < i_ctl.sel) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
